FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_HERE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_index;
        logic signed [31:0] head_key;
        logic               head_valid;
        logic [4:0]         entry_count;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the item and clear the walk state
        logic rd;      // read the entry at the walk index
        logic wr;      // process the read entry and advance the index
        logic fin;     // update the count and read the head entry
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more;    // another entry remains to be walked
    } sts_t;

endpackage

FILE: rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Key storage, walk index, count and result registers of the queue.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  spq_pkg::ctl_t    ctl,
    input  spq_pkg::item_t   item,
    output spq_pkg::sts_t    sts,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic signed [31:0] mem [CAPACITY];

    logic [1:0]         cmd_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] carry_reg, carry_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               hit_reg, hit_next;
    logic               placed_reg, placed_next;
    logic               full_reg;
    logic [1:0]         status_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [CW-1:0]      idx_dec;
    logic               at_end;
    logic               ge;
    logic               eq;

    assign idx_dec = idx_reg - ONE;
    assign at_end  = (idx_reg == count_reg);
    assign ge      = at_end || (rdata_reg >= key_reg);
    assign eq      = (rdata_reg == key_reg);

    always_comb
    begin
        sts.more = 1'b0;
        case (cmd_reg) inside
            CMD_INSERT: sts.more = !full_reg && (idx_reg <= count_reg);
            CMD_REMOVE,
            CMD_FIND:   sts.more = (idx_reg < count_reg);
            default:    sts.more = 1'b0;
        endcase
    end

    // One entry per walk step: insert carries displaced keys upward,
    // remove pulls every later key down by one, find only records the first match.
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = carry_reg;
        carry_next  = carry_reg;
        hit_next    = hit_reg;
        pos_next    = pos_reg;
        placed_next = placed_reg;
        if (ctl.wr)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (!placed_reg && ge)
                    begin
                        wr_en       = 1'b1;
                        wr_data     = key_reg;
                        carry_next  = rdata_reg;
                        placed_next = 1'b1;
                    end
                    else if (placed_reg)
                    begin
                        wr_en      = 1'b1;
                        carry_next = rdata_reg;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!hit_reg && eq)
                    begin
                        hit_next = 1'b1;
                        pos_next = idx_reg;
                    end
                    else if (hit_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_dec[AW-1:0];
                        wr_data = rdata_reg;
                    end
                end
                CMD_FIND:
                begin
                    if (!hit_reg && eq)
                    begin
                        hit_next = 1'b1;
                        pos_next = idx_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[idx_reg[AW-1:0]];
        end
        else if (ctl.fin)
        begin
            rdata_reg <= mem[0];
        end
        if (ctl.load)
        begin
            cmd_reg <= item.cmd;
            key_reg <= item.key;
        end
        carry_reg <= carry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            hit_reg    <= 1'b0;
            placed_reg <= 1'b0;
            full_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else if (ctl.load)
        begin
            idx_reg    <= '0;
            pos_reg    <= '0;
            hit_reg    <= 1'b0;
            placed_reg <= 1'b0;
            full_reg   <= (count_reg >= CAP_CNT);
        end
        else if (ctl.wr)
        begin
            idx_reg    <= idx_reg + ONE;
            pos_reg    <= pos_next;
            hit_reg    <= hit_next;
            placed_reg <= placed_next;
        end
        else if (ctl.fin)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    status_reg <= full_reg ? ST_FULL : ST_OK;
                    if (!full_reg)
                    begin
                        count_reg <= count_reg + ONE;
                    end
                end
                CMD_REMOVE:
                begin
                    status_reg <= hit_reg ? ST_OK : ST_NOT_HERE;
                    if (hit_reg)
                    begin
                        count_reg <= count_reg - ONE;
                    end
                end
                CMD_FIND: status_reg <= hit_reg ? ST_OK : ST_NOT_HERE;
                default:  status_reg <= ST_OK;
            endcase
        end
    end

    always_comb
    begin
        result.status      = status_reg;
        result.found_index = 4'(pos_reg);
        result.head_valid  = (count_reg != '0);
        result.head_key    = result.head_valid ? rdata_reg : 32'sd0;
        result.entry_count = 5'(count_reg);
    end

endmodule

FILE: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer that walks the stored keys one entry per read and write pair.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  spq_pkg::sts_t sts,
    output spq_pkg::ctl_t ctl,
    output logic          busy,
    output logic          done
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:   state_next = sts.more ? S_RD : S_FIN;
            S_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                ctl.wr     = 1'b1;
                state_next = S_CHK;
            end
            S_FIN:
            begin
                ctl.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Each item walks the stored keys one entry per read and write pair; insert walks
// count + 1 entries, remove and find walk count entries, a full insert or unused code
// none. The unit takes no new item while busy; busy is low again the cycle after done.
// Reset clears the count and the sequencer; key storage is not cleared.
// The result is shown for the one cycle that done is high; the receiver cannot stall.
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded ascending key queue with insert, remove and find commands.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  spq_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule

FILE: rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port level checks of the sorted priority queue unit.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input spq_pkg::result_t result
);
    import spq_pkg::*;

    // An accepted item keeps the unit busy until its result is out.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy && !$past(done))
        else $error("done outside a busy window or repeated");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.head_valid |-> result.head_key == 0 && result.entry_count == 0)
        else $error("empty queue reported a head key or a count");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_OK |-> result.found_index == 0)
        else $error("failed item reported a nonzero position");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
